FILE: rtl/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpc_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxWidth = 8;
  localparam logic [CfgIdxWidth-1:0] CFG_DEBOUNCE_TICKS   = 8'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_LONG_PRESS_TICKS = 8'd1;

  // field widths fixed by the interface
  localparam int unsigned CountWidth    = 16;
  localparam int unsigned DurationWidth = 16;

  // reset values of the configuration registers
  localparam logic [CountWidth-1:0] DebounceTicksRst  = 16'd50;
  localparam logic [CountWidth-1:0] LongPressTicksRst = 16'd500;

  // press event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_event_e;

  // one result beat
  typedef struct packed {
    logic                     debounced_level;
    press_event_e             press_event;
    logic [DurationWidth-1:0] press_duration;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/button_debounce_press_classifier.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces an active-low button sampled once per tick and classifies each
// release as a short or long press.
// ----------------------------------------------------------------------------
// path: an input beat reaches its result beat through the input register,
//   then the result register
// throughput: one tick per cycle; both registers advance together when the
//   result register is free or being drained
// reset: level released, counters cleared, thresholds 50 and 500 ticks
`default_nettype none

module button_debounce_press_classifier
  import bdpc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // [0] raw_level
  // result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [23:0]                 m_axis_tdata,   // [0] debounced_level,
                                                      // [16:1] press_duration
  output logic [1:0]                  m_axis_tuser,   // [1:0] press_event
  // configuration writes
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [CountWidth-1:0]  cfg_data_i
);

  logic                  in_valid_q;
  logic                  raw_q;
  logic                  out_valid_q;
  result_t               result_q;
  result_t               result;
  logic                  out_free;
  logic                  step;
  logic                  stable_level;
  logic [CountWidth-1:0] debounce_ticks_q;
  logic [CountWidth-1:0] long_press_ticks_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q   <= DebounceTicksRst;
      long_press_ticks_q <= LongPressTicksRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_DEBOUNCE_TICKS) begin
        debounce_ticks_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_LONG_PRESS_TICKS) begin
        long_press_ticks_q <= cfg_data_i;
      end
    end
  end

  // pipeline handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      raw_q <= s_axis_tdata[0];
    end
  end

  // per tick logic
  bdpc_debounce u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .raw_level_i      (raw_q),
    .debounce_ticks_i (debounce_ticks_q),
    .stable_level_o   (stable_level)
  );

  bdpc_press #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_press (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .stable_level_i     (stable_level),
    .long_press_ticks_i (long_press_ticks_q),
    .result_o           (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, result_q.press_duration, result_q.debounced_level};
  assign m_axis_tuser  = result_q.press_event;

  // a press is reported only on release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (result_q.press_event != EV_NONE) |-> result_q.debounced_level)
    else $error("press event without released level");

  // no event, no duration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (result_q.press_event == EV_NONE) |-> (result_q.press_duration == '0))
    else $error("duration reported without event");

  // classification agrees with the reported duration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (result_q.press_event == EV_LONG)
    |-> (result_q.press_duration >= long_press_ticks_q))
    else $error("long press shorter than threshold");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (result_q.press_event == EV_SHORT)
    |-> (result_q.press_duration < long_press_ticks_q))
    else $error("short press at or above threshold");

  // input stalls only behind a held tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q)
    else $error("input stalled with free pipeline");

endmodule

`default_nettype wire

FILE: rtl/bdpc_debounce.sv
// ----------------------------------------------------------------------------
// bdpc_debounce
// Mismatch counter and stable level; gives the stable level after this tick.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_debounce
  import bdpc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic                  raw_level_i,
  input  wire logic [CountWidth-1:0] debounce_ticks_i,
  output logic                       stable_level_o
);

  logic                  stable_q, stable_d;
  logic [CountWidth-1:0] mismatch_q, mismatch_d;
  logic [CountWidth-1:0] mismatch_inc;

  // saturating mismatch count and level acceptance
  always_comb begin
    mismatch_inc = (mismatch_q != '1) ? mismatch_q + 1'b1 : mismatch_q;
    stable_d     = stable_q;
    mismatch_d   = '0;
    if (raw_level_i != stable_q) begin
      if (mismatch_inc >= debounce_ticks_i) begin
        stable_d = raw_level_i;
      end else begin
        mismatch_d = mismatch_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= 1'b1;
      mismatch_q <= '0;
    end else if (step_i) begin
      stable_q   <= stable_d;
      mismatch_q <= mismatch_d;
    end
  end

  assign stable_level_o = stable_d;

endmodule

`default_nettype wire

FILE: rtl/bdpc_press.sv
// ----------------------------------------------------------------------------
// bdpc_press
// Press timer and edge classifier; builds one result from the stable level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_press
  import bdpc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic                  stable_level_i,
  input  wire logic [CountWidth-1:0] long_press_ticks_i,
  output result_t                    result_o
);

  localparam int unsigned CmpWidth = (TIMER_WIDTH > DurationWidth) ? TIMER_WIDTH
                                                                   : DurationWidth;

  logic                   prev_q;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic [TIMER_WIDTH-1:0] timer_inc;
  logic [CmpWidth-1:0]    timer_ext;
  logic [CmpWidth-1:0]    long_ext;
  result_t                result;

  // timer runs while the previous level is pressed, then edges are handled
  always_comb begin
    timer_inc = (!prev_q && (timer_q != '1)) ? timer_q + 1'b1 : timer_q;
    timer_ext = CmpWidth'(timer_inc);
    long_ext  = CmpWidth'(long_press_ticks_i);
    timer_d   = timer_inc;
    result.debounced_level = stable_level_i;
    result.press_event     = EV_NONE;
    result.press_duration  = '0;
    if (stable_level_i != prev_q) begin
      if (!stable_level_i) begin
        timer_d = '0;
      end else begin
        result.press_event    = (timer_ext >= long_ext) ? EV_LONG : EV_SHORT;
        result.press_duration = (timer_ext > CmpWidth'({DurationWidth{1'b1}}))
                                ? {DurationWidth{1'b1}} : timer_ext[DurationWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b1;
      timer_q <= '0;
    end else if (step_i) begin
      prev_q  <= stable_level_i;
      timer_q <= timer_d;
    end
  end

  assign result_o = result;

endmodule

`default_nettype wire

FILE: dv/button_debounce_press_classifier_tb.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_tb
// Self-checking bench for the button debouncer and press classifier. A short
// table of ticks covers zero and full-scale thresholds, bounces, short and
// long releases. Random press sequences with bounces, glitches and noise run
// under several threshold settings and idle patterns. Every result beat is
// compared against its pinned table value or an in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_press_classifier_tb;
  import bdpc_pkg::*;

  localparam int unsigned TimerWidth    = 16;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned StallLimit    = 20000;
  localparam int unsigned PhaseTicks    = 135;

  // directed row: either a register write or one tick
  typedef struct {
    bit                     is_cfg;
    logic [CfgIdxWidth-1:0] idx;
    logic [CountWidth-1:0]  val;
    logic                   raw;
    bit                     pin;
    result_t                want;
  } tick_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [23:0]            m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [CountWidth-1:0]  cfg_data_i = '0;

  // pinned expectation travelling with the current input beat
  bit      beat_pinned = 1'b0;
  result_t beat_want = '0;

  // idle control
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // model state and thresholds
  logic                  lvl_stable;
  logic                  lvl_prev;
  logic [15:0]           mis_cnt;
  logic [TimerWidth-1:0] press_timer;
  logic [CountWidth-1:0] thr_debounce;
  logic [CountWidth-1:0] thr_long;

  result_t     release_q[$];
  int unsigned fail_cnt = 0;
  int unsigned tick_cnt = 0;
  int unsigned short_cnt = 0;
  int unsigned long_cnt = 0;
  int unsigned write_cnt = 0;
  int unsigned quiet_cycles = 0;

  tick_row_t dir_rows [27] = '{
    '{1'b1, CFG_DEBOUNCE_TICKS,   16'd0, 1'b0, 1'b0, '0},
    '{1'b1, CFG_LONG_PRESS_TICKS, 16'd3, 1'b0, 1'b0, '0},
    // no debounce: one-tick press and release
    '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b1, EV_NONE,  16'd0}},
    '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, EV_NONE,  16'd0}},
    '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b1, EV_SHORT, 16'd1}},
    // press held exactly to the long threshold
    '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, EV_NONE,  16'd0}},
    '{1'b0, '0, '0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b1, EV_LONG,  16'd3}},
    // zero long threshold: any release is long
    '{1'b1, CFG_LONG_PRESS_TICKS, 16'd0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, EV_NONE,  16'd0}},
    '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b1, EV_LONG,  16'd1}},
    // bounce clears the mismatch count, then a clean press and release
    '{1'b1, CFG_DEBOUNCE_TICKS,   16'd3, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b1, EV_NONE,  16'd0}},
    '{1'b0, '0, '0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b0, EV_NONE,  16'd0}},
    '{1'b0, '0, '0, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, 1'b1, 1'b1, '{1'b1, EV_LONG,  16'd3}},
    // full-scale thresholds: a short press never gets through
    '{1'b1, CFG_DEBOUNCE_TICKS,   16'hFFFF, 1'b0, 1'b0, '0},
    '{1'b1, CFG_LONG_PRESS_TICKS, 16'hFFFF, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b1, EV_NONE,  16'd0}},
    '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b1, EV_NONE,  16'd0}},
    '{1'b0, '0, '0, 1'b0, 1'b1, '{1'b1, EV_NONE,  16'd0}}
  };

  button_debounce_press_classifier #(
    .TIMER_WIDTH(TimerWidth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // debounce one tick and classify a release
  function automatic result_t classify_tick(logic raw);
    result_t r;
    r = '{1'b1, EV_NONE, 16'd0};
    if (raw == lvl_stable) begin
      mis_cnt = '0;
    end else begin
      if (mis_cnt != 16'hFFFF) mis_cnt = mis_cnt + 16'd1;
      if (mis_cnt >= thr_debounce) begin
        lvl_stable = raw;
        mis_cnt = '0;
      end
    end
    // timer runs while the level was pressed before this tick
    if (!lvl_prev && press_timer != '1) press_timer = press_timer + 1'b1;
    if (lvl_stable != lvl_prev) begin
      if (!lvl_stable) begin
        press_timer = '0;
      end else begin
        r.press_event = (press_timer >= thr_long) ? EV_LONG : EV_SHORT;
        r.press_duration = (press_timer > 'hFFFF) ? 16'hFFFF
                                                  : press_timer[DurationWidth-1:0];
      end
      lvl_prev = lvl_stable;
    end
    r.debounced_level = lvl_stable;
    return r;
  endfunction

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldOffCycles;
    end
    if (hold_left != 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: track writes, predict each tick, check each result beat
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni) begin
      quiet_cycles++;
      if (cfg_valid_i && cfg_ready_o) begin
        quiet_cycles = 0;
        write_cnt++;
        if (cfg_index_i == CFG_DEBOUNCE_TICKS) thr_debounce = cfg_data_i;
        else if (cfg_index_i == CFG_LONG_PRESS_TICKS) thr_long = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        quiet_cycles = 0;
        tick_cnt++;
        want = classify_tick(s_axis_tdata[0]);
        release_q.push_back(beat_pinned ? beat_want : want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        got.debounced_level = m_axis_tdata[0];
        got.press_duration  = m_axis_tdata[16:1];
        got.press_event     = press_event_e'(m_axis_tuser);
        if (release_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt++;
        end else begin
          want = release_q.pop_front();
          if (want.press_event == EV_SHORT) short_cnt++;
          if (want.press_event == EV_LONG) long_cnt++;
          if (got.debounced_level !== want.debounced_level) begin
            $error("debounced_level: expected %0d, got %0d",
                   want.debounced_level, got.debounced_level);
            fail_cnt++;
          end
          if (got.press_event !== want.press_event) begin
            $error("press_event: expected %0d, got %0d",
                   want.press_event, got.press_event);
            fail_cnt++;
          end
          if (got.press_duration !== want.press_duration) begin
            $error("press_duration: expected %0d, got %0d",
                   want.press_duration, got.press_duration);
            fail_cnt++;
          end
        end
      end
      // watchdog
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no beat for %0d cycles", quiet_cycles);
        $display("button_debounce_press_classifier_tb failed");
        $finish;
      end
    end
  end

  // offer one tick, wait for its handshake; valid stays up afterwards
  task automatic send_tick(input logic raw, input bit pin, input result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'd0, raw};
    beat_pinned   = pin;
    beat_want     = want;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // drain everything, then write one register
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CountWidth-1:0] val);
    s_axis_tvalid = 1'b0;
    while (release_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // one press with bounces and glitches, or a burst of noise
  task automatic press_episode(input int unsigned db, input int unsigned lng,
                               inout int unsigned sent);
    int unsigned span;
    int unsigned len;
    if ($urandom_range(99) < 20) begin
      len = $urandom_range(1, 8);
      repeat (len) send_tick(1'($urandom_range(1)), 1'b0, '0);
      sent += len;
    end else begin
      // bounces on the way down
      repeat ($urandom_range(0, 3)) begin
        len = $urandom_range(1, (db > 0) ? db : 1);
        repeat (len) send_tick(1'b0, 1'b0, '0);
        send_tick(1'b1, 1'b0, '0);
        sent += len + 1;
      end
      // hold with rare glitches
      span = db + 2 * lng + 4;
      if (span > 90) span = 90;
      len = $urandom_range(db + 1, span);
      repeat (len) send_tick(($urandom_range(99) < 8), 1'b0, '0);
      // release with rare glitches
      span = $urandom_range(db + 1, db + 10);
      repeat (span) send_tick(($urandom_range(99) >= 8), 1'b0, '0);
      sent += len + span;
    end
  endtask

  initial begin
    int unsigned idle_mode [4][2] = '{'{0, 0}, '{64, 0}, '{0, 64}, '{17, 17}};
    int unsigned db_set [8]   = '{0, 1, 3, 5, 2, 4, 6, 1};
    int unsigned long_set [8] = '{0, 4, 10, 25, 65535, 1, 15, 8};
    int unsigned sent;

    lvl_stable   = 1'b1;
    lvl_prev     = 1'b1;
    mis_cnt      = '0;
    press_timer  = '0;
    thr_debounce = DebounceTicksRst;
    thr_long     = LongPressTicksRst;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_tick(dir_rows[i].raw, dir_rows[i].pin, dir_rows[i].want);
      end
    end

    // random press sequences under each idle pattern and threshold setting
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_DEBOUNCE_TICKS, CountWidth'(db_set[p]));
      write_reg(CFG_LONG_PRESS_TICKS, CountWidth'(long_set[p]));
      send_idle_pct  = idle_mode[p % 4][0];
      recv_stall_pct = idle_mode[p % 4][1];
      // long receiver hold-off while ticks keep coming
      if (p == 0) hold_req++;
      sent = 0;
      while (sent < PhaseTicks) press_episode(db_set[p], long_set[p], sent);
    end

    // drain and settle
    s_axis_tvalid = 1'b0;
    while (release_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("ran %0d ticks through %0d register writes", tick_cnt, write_cnt);
    $display("saw %0d short and %0d long releases under mixed stalls",
             short_cnt, long_cnt);
    if (fail_cnt == 0) begin
      $display("button_debounce_press_classifier_tb passed");
    end else begin
      $display("button_debounce_press_classifier_tb failed");
    end
    $finish;
  end

endmodule
